/* rtl/rrss_pkg.sv */
`default_nettype none
package rrss_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int VAL_W     = 16;
  localparam int TIME_W    = 24;
  localparam int WAIT_W    = 28;
  localparam int IDX_W     = 4;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [TIME_W-1:0] TICK_MAX = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // register index, byte address 4*index
  localparam logic [CFG_AW-3:0] REG_QUANTUM = '0;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RD_WALK,
    RD_HEAD,
    RD_SEL
  } rd_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD,
    ST_RUN,
    ST_WAIT,
    ST_SUM,
    ST_HSCAN,
    ST_PTR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] arrival_time;
    logic [VAL_W-1:0] burst_length;
  } in_word_t;

  typedef struct packed {
    logic              slice_valid;
    logic [IDX_W-1:0]  task_index;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              task_finished;
    logic              all_finished;
    logic [WAIT_W-1:0] wait_total;
  } out_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] remaining;
  } entry_t;

  typedef struct packed {
    rd_src_t rd_src;
    logic    load;
    logic    clear;
    logic    start;
    logic    walk_step;
    logic    sel_walk;
    logic    head_pick;
    logic    run;
    logic    wait_calc;
    logic    sum_upd;
    logic    hscan_init;
    logic    head_set;
    logic    ptr_upd;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic nothing;
    logic walk_end;
    logic scan_stop;
    logic hit;
    logic run_done;
    logic sel_is_head;
    logic out_blocked;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/round_robin_slice_scheduler_top.sv */
// Load and clear words are taken in the idle state and give no result word.
// A dispatch word goes straight to the emit when nothing can run; else the scan reads
// one slot per cycle, a completion adds the wait and sum steps and the head search walks
// one slot per cycle. A stalled result word holds the emit. One word is in work at a time;
// the next is taken once the emit has returned the control to its idle state.
// Synchronous active-low reset empties the task table and sets the quantum to 4.
`default_nettype none
module round_robin_slice_scheduler_top
  import rrss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [VAL_W-1:0] quantum_r;
  logic             cfg_hit;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_AW-1:2] == REG_QUANTUM;
  assign cfg_prdata = cfg_hit ? CFG_DW'(quantum_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= VAL_W'(4);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      quantum_r <= cfg_pwdata[VAL_W-1:0];
    end
  end

  rrss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rrss_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .quantum   (quantum_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.op == OP_DISPATCH)) |=> in_stall)
    else $error("dispatch word did not hold off the input");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("result word not presented after emit");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clear, cmd.start, cmd.head_pick, cmd.run, cmd.emit}))
    else $error("conflicting datapath commands");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result word overwritten while stalled");

endmodule
`default_nettype wire

/* rtl/rrss_ctrl.sv */
`default_nettype none
module rrss_ctrl
  import rrss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  input  wire sts_t       sts,
  output logic            in_stall,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_src = RD_WALK;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_op)
            OP_LOAD:  cmd.load = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            OP_DISPATCH: begin
              cmd.start = 1'b1;
              state_nxt = sts.nothing ? ST_EMIT : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_src = RD_WALK;
        if (sts.scan_stop) begin
          state_nxt = ST_HEAD;
        end else if (sts.hit) begin
          cmd.sel_walk = 1'b1;
          state_nxt    = ST_RUN;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_HEAD: begin
        cmd.rd_src    = RD_HEAD;
        cmd.head_pick = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        cmd.rd_src = RD_SEL;
        cmd.run    = 1'b1;
        state_nxt  = sts.run_done ? ST_WAIT : ST_PTR;
      end
      ST_WAIT: begin
        cmd.wait_calc = 1'b1;
        state_nxt     = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_upd    = 1'b1;
        cmd.hscan_init = 1'b1;
        state_nxt      = sts.sel_is_head ? ST_HSCAN : ST_PTR;
      end
      ST_HSCAN: begin
        cmd.rd_src = RD_WALK;
        if (sts.walk_end) begin
          state_nxt = ST_PTR;
        end else if (sts.hit) begin
          cmd.head_set = 1'b1;
          state_nxt    = ST_PTR;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_PTR: begin
        cmd.ptr_upd = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_blocked) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rrss_dpath.sv */
`default_nettype none
module rrss_dpath
  import rrss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [VAL_W-1:0] quantum,
  input  wire in_word_t         in_data,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output out_word_t             out_data
);

  entry_t tbl_r [MAX_TASKS];

  logic [CNT_W-1:0]  task_cnt_r, scan_ptr_r, head_r, done_r, walk_r;
  logic [TIME_W-1:0] now_r, start_r, wait_r;
  logic [WAIT_W-1:0] wsum_r;
  logic [SLOT_W-1:0] sel_r;
  logic [VAL_W:0]    ab_r;
  logic              fin_r, idle_r, out_valid_r;
  out_word_t         out_data_r;

  logic [SLOT_W-1:0] rd_addr;
  entry_t            rd;
  logic [VAL_W-1:0]  q_eff, run_len, rem_left, load_burst;
  logic [TIME_W-1:0] arr_ext, now_adv;
  logic [TIME_W:0]   now_sum;
  logic [WAIT_W:0]   wsum_sum;
  logic [CNT_W-1:0]  sel_ext, sel_inc;
  logic              load_ok;

  always_comb begin
    case (cmd.rd_src)
      RD_HEAD: rd_addr = head_r[SLOT_W-1:0];
      RD_SEL:  rd_addr = sel_r;
      default: rd_addr = walk_r[SLOT_W-1:0];
    endcase
  end

  assign rd         = tbl_r[rd_addr];
  assign arr_ext    = TIME_W'(rd.arrival);
  assign q_eff      = (quantum == '0) ? VAL_W'(1) : quantum;
  assign run_len    = (rd.remaining < q_eff) ? rd.remaining : q_eff;
  assign rem_left   = (rd.remaining < q_eff) ? '0 : rd.remaining - q_eff;
  assign now_sum    = {1'b0, now_r} + (TIME_W + 1)'(run_len);
  assign now_adv    = now_sum[TIME_W] ? TICK_MAX : now_sum[TIME_W-1:0];
  assign wsum_sum   = {1'b0, wsum_r} + (WAIT_W + 1)'(wait_r);
  assign sel_ext    = CNT_W'(sel_r);
  assign sel_inc    = sel_ext + 1'b1;
  assign load_burst = (in_data.burst_length == '0) ? VAL_W'(1) : in_data.burst_length;
  assign load_ok    = cmd.load && (task_cnt_r < CNT_W'(MAX_TASKS));

  assign sts.nothing     = (done_r >= task_cnt_r) || (head_r >= task_cnt_r);
  assign sts.walk_end    = walk_r >= task_cnt_r;
  assign sts.scan_stop   = sts.walk_end || (arr_ext > now_r);
  assign sts.hit         = rd.remaining != '0;
  assign sts.run_done    = rem_left == '0;
  assign sts.sel_is_head = sel_ext == head_r;
  assign sts.out_blocked = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_cnt_r  <= '0;
      now_r       <= '0;
      scan_ptr_r  <= '0;
      head_r      <= '0;
      done_r      <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        task_cnt_r <= '0;
        now_r      <= '0;
        scan_ptr_r <= '0;
        head_r     <= '0;
        done_r     <= '0;
        wsum_r     <= '0;
      end
      if (load_ok) begin
        if (done_r >= task_cnt_r) begin
          head_r <= task_cnt_r;
        end
        task_cnt_r <= task_cnt_r + 1'b1;
      end
      if (cmd.head_pick && (head_r < task_cnt_r) && (arr_ext > now_r)) begin
        now_r <= arr_ext;
      end
      if (cmd.run) begin
        now_r <= now_adv;
        if (sts.run_done) begin
          done_r <= done_r + 1'b1;
        end
      end
      if (cmd.sum_upd) begin
        wsum_r <= wsum_sum[WAIT_W] ? WAIT_MAX : wsum_sum[WAIT_W-1:0];
      end
      if (cmd.head_set) begin
        head_r <= walk_r;
      end
      if (cmd.ptr_upd) begin
        scan_ptr_r <= (sel_inc >= task_cnt_r) ? head_r : sel_inc;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      walk_r <= scan_ptr_r;
      idle_r <= sts.nothing;
    end
    if (cmd.walk_step) begin
      walk_r <= walk_r + 1'b1;
    end
    if (cmd.hscan_init) begin
      walk_r <= head_r + 1'b1;
    end
    if (cmd.sel_walk) begin
      sel_r <= walk_r[SLOT_W-1:0];
    end
    if (cmd.head_pick) begin
      sel_r <= head_r[SLOT_W-1:0];
    end
    if (load_ok) begin
      tbl_r[task_cnt_r[SLOT_W-1:0]] <= '{arrival: in_data.arrival_time,
                                         burst: load_burst,
                                         remaining: load_burst};
    end
    if (cmd.run) begin
      start_r                  <= now_r;
      fin_r                    <= sts.run_done;
      ab_r                     <= {1'b0, rd.arrival} + {1'b0, rd.burst};
      tbl_r[sel_r].remaining   <= rem_left;
    end
    if (cmd.wait_calc) begin
      wait_r <= (now_r > TIME_W'(ab_r)) ? now_r - TIME_W'(ab_r) : '0;
    end
    if (cmd.emit) begin
      if (idle_r) begin
        out_data_r <= '{slice_valid: 1'b0, task_index: '0, slice_start: now_r,
                        slice_end: now_r, task_finished: 1'b0, all_finished: 1'b1,
                        wait_total: wsum_r};
      end else begin
        out_data_r <= '{slice_valid: 1'b1, task_index: IDX_W'(sel_r),
                        slice_start: start_r, slice_end: now_r, task_finished: fin_r,
                        all_finished: (done_r >= task_cnt_r), wait_total: wsum_r};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* sim/rrss_slice_checker.sv */
`default_nettype none
module rrss_slice_checker
  import rrss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire in_word_t          in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire out_word_t         out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic              cfg_pready,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output int                     fail_count,
  output int                     slices_pending,
  output int                     words_seen,
  output int                     slices_seen,
  output int                     tasks_completed,
  output int                     idle_slices
);

  localparam logic [CFG_AW-1:0] QUANTUM_ADDR = {REG_QUANTUM, 2'b00};

  logic [VAL_W-1:0] arr_tab [MAX_TASKS];
  logic [VAL_W-1:0] bur_tab [MAX_TASKS];
  logic [VAL_W-1:0] rem_tab [MAX_TASKS];
  logic [VAL_W-1:0] quantum;
  int n_tasks, n_done, now_t, scan_ptr, head, wsum;
  out_word_t slices_due [$];

  task automatic clear_table();
    for (int i = 0; i < MAX_TASKS; i++) begin
      arr_tab[i] = '0;
      bur_tab[i] = '0;
      rem_tab[i] = '0;
    end
    n_tasks  = 0;
    n_done   = 0;
    now_t    = 0;
    scan_ptr = 0;
    head     = 0;
    wsum     = 0;
  endtask

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 100) $display("%s", msg);
  endtask

  task automatic field_check(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want)
      report($sformatf("slice %0d %s: expected %0h, got %0h", slices_seen, name, want, seen));
  endtask

  // walk from the scan pointer; fall back to the head, idling time up to its arrival
  function automatic int next_slot();
    int p, k;
    bit found;
    p = scan_ptr;
    k = 0;
    found = 1'b0;
    while (!found && k < MAX_TASKS + 2 && p < n_tasks && arr_tab[p] <= now_t) begin
      if (rem_tab[p] != 0) begin
        found = 1'b1;
      end else begin
        p++;
        k++;
      end
    end
    if (!found) begin
      if (head < n_tasks && arr_tab[head] > now_t) now_t = arr_tab[head];
      p = head;
    end
    return p;
  endfunction

  function automatic out_word_t run_slice();
    out_word_t e;
    int p, q, run, start, a, b, wt, i;
    logic fin;
    e = '0;
    if (n_done >= n_tasks || head >= n_tasks) begin
      e.slice_start  = TIME_W'(now_t);
      e.slice_end    = TIME_W'(now_t);
      e.all_finished = 1'b1;
      e.wait_total   = WAIT_W'(wsum);
      return e;
    end
    p = next_slot();
    q = (quantum == 0) ? 1 : quantum;
    run = (rem_tab[p] < q) ? rem_tab[p] : q;
    start = now_t;
    now_t = (now_t + run > TICK_MAX) ? TICK_MAX : now_t + run;
    rem_tab[p] = rem_tab[p] - VAL_W'(run);
    fin = (rem_tab[p] == 0);
    if (fin) begin
      n_done++;
      a = arr_tab[p];
      b = bur_tab[p];
      wt = (now_t > a + b) ? now_t - a - b : 0;
      wsum = (wsum + wt > WAIT_MAX) ? WAIT_MAX : wsum + wt;
      if (p == head) begin
        i = head + 1;
        while (i < n_tasks && rem_tab[i] == 0) i++;
        if (i < n_tasks) head = i;
      end
    end
    scan_ptr = (p + 1 >= n_tasks) ? head : p + 1;
    e.slice_valid   = 1'b1;
    e.task_index    = IDX_W'(p);
    e.slice_start   = TIME_W'(start);
    e.slice_end     = TIME_W'(now_t);
    e.task_finished = fin;
    e.all_finished  = (n_done >= n_tasks);
    e.wait_total    = WAIT_W'(wsum);
    return e;
  endfunction

  task automatic apply_word(in_word_t w);
    case (w.op)
      OP_LOAD: begin
        if (n_tasks < MAX_TASKS) begin
          if (n_done >= n_tasks) head = n_tasks;
          arr_tab[n_tasks] = w.arrival_time;
          bur_tab[n_tasks] = (w.burst_length == 0) ? VAL_W'(1) : w.burst_length;
          rem_tab[n_tasks] = bur_tab[n_tasks];
          n_tasks++;
        end
      end
      OP_DISPATCH: slices_due = {slices_due, run_slice()};
      OP_CLEAR: clear_table();
      default: ;
    endcase
  endtask

  task automatic check_slice(out_word_t got);
    out_word_t e;
    if (slices_due.size() == 0) begin
      report($sformatf("unexpected slice word %0h", got));
      return;
    end
    e = slices_due.pop_front();
    field_check("slice_valid", e.slice_valid, got.slice_valid);
    field_check("task_index", e.task_index, got.task_index);
    field_check("slice_start", e.slice_start, got.slice_start);
    field_check("slice_end", e.slice_end, got.slice_end);
    field_check("task_finished", e.task_finished, got.task_finished);
    field_check("all_finished", e.all_finished, got.all_finished);
    field_check("wait_total", e.wait_total, got.wait_total);
    slices_seen++;
    if (e.task_finished) tasks_completed++;
    if (!e.slice_valid) idle_slices++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      quantum = VAL_W'(4);
      clear_table();
      slices_due.delete();
      fail_count      = 0;
      slices_pending  = 0;
      words_seen      = 0;
      slices_seen     = 0;
      tasks_completed = 0;
      idle_slices     = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == QUANTUM_ADDR)
        quantum = cfg_pwdata[VAL_W-1:0];
      if (out_valid && !out_stall) check_slice(out_data);
      if (in_valid && !in_stall) begin
        words_seen++;
        apply_word(in_data);
      end
      slices_pending = slices_due.size();
    end
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;
  import rrss_pkg::*;

  localparam logic [1:0]        OP_UNUSED    = 2'd3;
  localparam logic [CFG_AW-1:0] QUANTUM_ADDR = {REG_QUANTUM, 2'b00};
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = MAX_TASKS + 14;
  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES  = 600;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count, slices_pending, words_seen, slices_seen, tasks_completed, idle_slices;
  int cycles = 0;
  int quantum_now, settings, words_sent;
  bit no_gaps;

  round_robin_slice_scheduler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  rrss_slice_checker slice_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .slices_pending(slices_pending), .words_seen(words_seen),
    .slices_seen(slices_seen), .tasks_completed(tasks_completed), .idle_slices(idle_slices)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("round_robin_slice_scheduler_top regression: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic [1:0] op, int arr, int bur);
    in_word_t w;
    int gap;
    w.op           = op;
    w.arrival_time = VAL_W'(arr);
    w.burst_length = VAL_W'(bur);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (slices_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_quantum(int value);
    settle();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= QUANTUM_ADDR;
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    quantum_now = value;
    settings++;
  endtask

  // receiver: random stalls, calm windows, and periodic long hold-offs
  initial begin : receiver
    int cyc, next_hold, n, k, window;
    bit calm;
    out_stall = 1'b0;
    cyc = 0;
    next_hold = 2000;
    window = 0;
    calm = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (cyc >= next_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        cyc += HOLD_CYCLES;
        next_hold += 30000;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(negedge clk);
        cyc++;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          cyc += n;
        end
        out_stall <= 1'b0;
        k = $urandom_range(1, 6);
        repeat (k) @(negedge clk);
        cyc += k;
      end
      if (cyc / 300 != window) begin
        window = cyc / 300;
        calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin : stimulus
    int scen, ntasks, ndisp, slices, qeff, t, b, inc, k;
    bit sorted;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quantum_now = 4;
    settings    = 0;
    words_sent  = 0;
    no_gaps     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero quantum behaves as one tick
    write_quantum(0);
    send_word(OP_DISPATCH, 0, 0);
    send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_word(OP_LOAD, 0, 0);
    send_word(OP_LOAD, 1, 2);
    send_word(OP_LOAD, 30, 1);
    repeat (6) send_word(OP_DISPATCH, 16'hFFFF, 16'hFFFF);
    // load after everything finished: head moves up, time idles to arrival
    send_word(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_word(OP_DISPATCH, 0, 0);
    send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    write_quantum(16'hFFFF);
    send_word(OP_LOAD, 16'hFFFF, 16'hFFFF);
    send_word(OP_LOAD, 16'hFFFF, 1);
    repeat (3) send_word(OP_DISPATCH, 0, 0);

    words_sent = 0;
    scen = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (scen % 6 == 5) begin
        if (scen == 5) begin
          write_quantum(1);
        end else begin
          case ($urandom_range(0, 7))
            0: write_quantum(1);
            1: write_quantum(2);
            2: write_quantum(4);
            3: write_quantum($urandom_range(3, 16));
            4: write_quantum(16'hFFFF);
            5: write_quantum($urandom_range(17, 300));
            default: write_quantum($urandom_range(1, 65535));
          endcase
        end
      end
      qeff = (quantum_now == 0) ? 1 : quantum_now;
      no_gaps = ($urandom_range(0, 3) == 0);
      if (scen < 2 || $urandom_range(0, 9) != 0) send_word(OP_CLEAR, $urandom, $urandom);
      if (scen == 1) ntasks = MAX_TASKS + 2;
      else if ($urandom_range(0, 4) == 0) ntasks = $urandom_range(9, MAX_TASKS);
      else ntasks = $urandom_range(1, 8);
      sorted = ($urandom_range(0, 9) != 0);
      t = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      slices = 0;
      for (k = 0; k < ntasks; k++) begin
        if (sorted) begin
          if ($urandom_range(0, 7) == 0) inc = $urandom_range(0, 3000);
          else inc = $urandom_range(0, (qeff * 2 > 2000) ? 2000 : qeff * 2);
          t = (t + inc > 65535) ? 65535 : t + inc;
        end else begin
          t = $urandom_range(0, 65535);
        end
        case ($urandom_range(0, 19))
          0: b = 0;
          1: b = $urandom_range(0, 65535);
          default: b = $urandom_range(1, (qeff * 3 > 65535) ? 65535 : qeff * 3);
        endcase
        slices += ((b == 0 ? 1 : b) + qeff - 1) / qeff;
        send_word(OP_LOAD, t, b);
        if ($urandom_range(0, 99) < 15) send_word(OP_DISPATCH, $urandom, $urandom);
        if ($urandom_range(0, 99) < 3) send_word(OP_UNUSED, $urandom, $urandom);
      end
      ndisp = slices + $urandom_range(0, 3);
      if (ndisp > 80) ndisp = 80;
      repeat (ndisp) begin
        send_word(OP_DISPATCH, $urandom, $urandom);
        if ($urandom_range(0, 99) < 3) send_word(OP_UNUSED, $urandom, $urandom);
      end
      scen++;
    end

    settle();
    $display("covered %0d input words and %0d slices: %0d tasks ran to completion, %0d dispatches found nothing to run",
             words_seen, slices_seen, tasks_completed, idle_slices);
    $display("quantum went through %0d settings including zero and both ends of its range",
             settings);
    if (fail_count == 0) begin
      $display("round_robin_slice_scheduler_top regression: pass");
    end else begin
      $display("round_robin_slice_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
